>>> src/degenerate_triangle_filter_unit_macros.svh
// Assertion macros shared by the degenerate triangle filter modules.
`ifndef DEGENERATE_TRIANGLE_FILTER_UNIT_MACROS_SVH
`define DEGENERATE_TRIANGLE_FILTER_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DTF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DTF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/dtf_pkg.sv
// Package of types, constants and commands for the degenerate triangle filter.
`default_nettype none

package dtf_pkg;

	localparam int unsigned MAX_TRIANGLES = 65536;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned SQ_W    = 2 * COORD_W;
	localparam int unsigned RAD_W   = SQ_W + 2;
	localparam int unsigned ROOT_W  = RAD_W / 2;
	localparam int unsigned REM_W   = ROOT_W + 1;
	localparam int unsigned LEN_W   = ROOT_W;
	localparam int unsigned IDX_W   = 18;
	localparam int unsigned CNT_W   = 17;

	localparam longint unsigned IDX_CAP_RAW = 3 * (longint'(MAX_TRIANGLES) - 1);
	localparam longint unsigned IDX_FIELD_MAX = (64'd1 << IDX_W) - 1;
	localparam longint unsigned CNT_FIELD_MAX = (64'd1 << CNT_W) - 1;
	localparam logic [IDX_W-1:0] IDX_CAP =
		IDX_W'((IDX_CAP_RAW > IDX_FIELD_MAX) ? IDX_FIELD_MAX : IDX_CAP_RAW);
	localparam logic [CNT_W-1:0] CNT_CAP =
		CNT_W'((longint'(MAX_TRIANGLES) > CNT_FIELD_MAX) ? CNT_FIELD_MAX
			: longint'(MAX_TRIANGLES));

	// Sequencer step counter: squaring phase and root phase share it.
	localparam int unsigned SQ_LAST   = 4;
	localparam int unsigned ROOT_LAST = ROOT_W + 1;
	localparam int unsigned STEP_W    = $clog2(ROOT_LAST + 1);

	localparam logic [1:0] EDGE_AC = 2'd0;
	localparam logic [1:0] EDGE_BC = 2'd1;
	localparam logic [1:0] EDGE_AB = 2'd2;

	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef struct packed {
		logic                       first_of_mesh;
		logic signed [COORD_W-1:0]  a_x;
		logic signed [COORD_W-1:0]  a_y;
		logic signed [COORD_W-1:0]  a_z;
		logic signed [COORD_W-1:0]  b_x;
		logic signed [COORD_W-1:0]  b_y;
		logic signed [COORD_W-1:0]  b_z;
		logic signed [COORD_W-1:0]  c_x;
		logic signed [COORD_W-1:0]  c_y;
		logic signed [COORD_W-1:0]  c_z;
	} dtf_in_t;

	typedef struct packed {
		logic              keep;
		logic [IDX_W-1:0]  new_first_index;
		logic [CNT_W-1:0]  removed_count;
	} dtf_out_t;

	typedef struct packed {
		logic        load;
		logic [1:0]  edge_sel;
		logic [1:0]  comp_sel;
		logic        diff_en;
		logic        sq_en;
		logic        acc_en;
		logic        acc_clr;
		logic        root_init;
		logic        root_step;
		logic        len_wr;
		logic        commit;
	} dtf_cmd_t;

	typedef struct packed {
		logic  out_free;
	} dtf_stat_t;

endpackage

`default_nettype wire

>>> src/degenerate_triangle_filter_unit.sv
// Top level of the degenerate triangle filter: sequencer plus datapath.
// One triangle request at a time: after acceptance each edge (AC, BC, AB)
// has its component differences squared and summed, then goes through the
// shared restoring square-root unit, which retires one root bit per cycle;
// a decision step then stores the result, waiting while the previous result
// is still held untaken. The result sits in an output register, so the next
// request is accepted as soon as the previous result is stored, even while
// it still waits to be taken. No clearing pass after reset.
`default_nettype none

module degenerate_triangle_filter_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire dtf_pkg::dtf_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output dtf_pkg::dtf_out_t     out_data
);
	import dtf_pkg::*;

	dtf_cmd_t  cmd;
	dtf_stat_t stat;

	dtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dtf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> src/dtf_ctrl.sv
// Sequencer that steps the datapath through the edge lengths (AC, BC, AB) and the keep decision.
`default_nettype none

`include "degenerate_triangle_filter_unit_macros.svh"

module dtf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire dtf_pkg::dtf_stat_t stat,
	output dtf_pkg::dtf_cmd_t      cmd
);
	import dtf_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SQ     = 2'd1;
	localparam logic [1:0] S_ROOT   = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        edge_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.edge_sel = edge_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_SQ: begin
				// diff of component t, square of t-1, accumulate t-2
				cmd.diff_en  = (step_q <= STEP_W'(2));
				cmd.comp_sel = (step_q <= STEP_W'(2)) ? step_q[1:0] : COMP_X;
				cmd.sq_en    = (step_q >= STEP_W'(1)) && (step_q <= STEP_W'(3));
				cmd.acc_en   = (step_q >= STEP_W'(2));
				cmd.acc_clr  = (step_q == STEP_W'(2));
			end
			S_ROOT: begin
				cmd.root_init = (step_q == '0);
				cmd.root_step = (step_q != '0) && (step_q != STEP_W'(ROOT_LAST));
				cmd.len_wr    = (step_q == STEP_W'(ROOT_LAST));
			end
			S_DECIDE: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd.commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			edge_q  <= EDGE_AC;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQ;
						step_q  <= '0;
						edge_q  <= EDGE_AC;
					end
				end
				S_SQ: begin
					if (step_q == STEP_W'(SQ_LAST)) begin
						state_q <= S_ROOT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ROOT: begin
					if (step_q == STEP_W'(ROOT_LAST)) begin
						step_q <= '0;
						if (edge_q == EDGE_AB) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SQ;
							edge_q  <= edge_q + 2'd1;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_DECIDE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DTF_ASSERT(a_load_starts_sq, cmd.load |=> (state_q == S_SQ), "accepted request did not start squaring")
	`DTF_NEVER(a_edge_range, (state_q != S_IDLE) && (edge_q == 2'd3), "edge select out of range")
	`DTF_ASSERT(a_sq_to_root, (state_q == S_SQ) && (step_q == STEP_W'(SQ_LAST)) |=> (state_q == S_ROOT) && (step_q == '0), "squaring did not hand over to root")

endmodule

`default_nettype wire

>>> src/dtf_dp.sv
// Datapath: edge differences, squares, shared restoring square root, decision and counters.
`default_nettype none

`include "degenerate_triangle_filter_unit_macros.svh"

module dtf_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtf_pkg::dtf_in_t  in_data,
	input  wire dtf_pkg::dtf_cmd_t cmd,
	output dtf_pkg::dtf_stat_t     stat,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dtf_pkg::dtf_out_t      out_data
);
	import dtf_pkg::*;

	dtf_in_t                    in_q;
	logic [COORD_W-1:0]         diff_q;
	logic [SQ_W-1:0]            sq_q;
	logic [RAD_W-1:0]           acc_q;
	logic [RAD_W-1:0]           rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [LEN_W-1:0]           len_q [3];
	logic [IDX_W-1:0]           nvi_q;
	logic [CNT_W-1:0]           deg_q;
	dtf_out_t                   out_q;
	logic                       out_valid_q;

	logic signed [COORD_W-1:0]  p_a, p_b, p_c, p_sel, q_sel;
	logic signed [COORD_W:0]    diff;
	logic signed [COORD_W:0]    mag;
	logic [REM_W+1:0]           rem_sh;
	logic [REM_W+1:0]           trial;
	logic                       take;
	logic [LEN_W:0]             s01, s02, s12;
	logic                       ok;
	logic [IDX_W-1:0]           base_idx;
	logic [CNT_W-1:0]           base_cnt;
	logic [IDX_W:0]             idx_next;

	// Pick the component of each vertex, then the edge endpoints.
	always_comb begin
		case (cmd.comp_sel)
			COMP_X: begin
				p_a = in_q.a_x; p_b = in_q.b_x; p_c = in_q.c_x;
			end
			COMP_Y: begin
				p_a = in_q.a_y; p_b = in_q.b_y; p_c = in_q.c_y;
			end
			COMP_Z: begin
				p_a = in_q.a_z; p_b = in_q.b_z; p_c = in_q.c_z;
			end
			default: begin
				p_a = in_q.a_x; p_b = in_q.b_x; p_c = in_q.c_x;
			end
		endcase
		p_sel = (cmd.edge_sel == EDGE_BC) ? p_b : p_a;
		q_sel = (cmd.edge_sel == EDGE_AB) ? p_b : p_c;
		diff  = (COORD_W+1)'(p_sel) - (COORD_W+1)'(q_sel);
		mag   = diff[COORD_W] ? -diff : diff;
	end

	// One root bit per step: bring down two radicand bits, try 4*root+1.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.diff_en) begin
			diff_q <= mag[COORD_W-1:0];
		end
		if (cmd.sq_en) begin
			sq_q <= SQ_W'(diff_q) * SQ_W'(diff_q);
		end
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_clr ? RAD_W'(sq_q) : acc_q + RAD_W'(sq_q);
		end
		if (cmd.root_init) begin
			rad_q  <= acc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.len_wr) begin
			len_q[cmd.edge_sel] <= root_q;
		end
		if (cmd.commit) begin
			out_q.keep            <= ok;
			out_q.new_first_index <= ok ? base_idx : '0;
			out_q.removed_count   <= ok ? base_cnt
				: ((base_cnt < CNT_CAP) ? base_cnt + CNT_W'(1) : base_cnt);
		end
	end

	// Strict triangle inequalities on the rounded lengths.
	assign s01 = (LEN_W+1)'(len_q[0]) + (LEN_W+1)'(len_q[1]);
	assign s02 = (LEN_W+1)'(len_q[0]) + (LEN_W+1)'(len_q[2]);
	assign s12 = (LEN_W+1)'(len_q[1]) + (LEN_W+1)'(len_q[2]);
	assign ok  = (s01 > (LEN_W+1)'(len_q[2])) && (s02 > (LEN_W+1)'(len_q[1]))
		&& (s12 > (LEN_W+1)'(len_q[0]));

	assign base_idx = in_q.first_of_mesh ? '0 : nvi_q;
	assign base_cnt = in_q.first_of_mesh ? '0 : deg_q;
	assign idx_next = (IDX_W+1)'(base_idx) + (IDX_W+1)'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvi_q       <= '0;
			deg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (ok) begin
					nvi_q <= (idx_next <= (IDX_W+1)'(IDX_CAP)) ? idx_next[IDX_W-1:0] : IDX_CAP;
					deg_q <= base_cnt;
				end else begin
					nvi_q <= base_idx;
					deg_q <= (base_cnt < CNT_CAP) ? base_cnt + CNT_W'(1) : base_cnt;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	`DTF_NEVER(a_commit_blocked, cmd.commit && out_valid_q && out_stall, "result overwritten while stalled")
	`DTF_ASSERT(a_valid_from_commit, $rose(out_valid_q) |-> $past(cmd.commit), "result appeared without a commit")
	`DTF_NEVER(a_idx_cap, nvi_q > IDX_CAP, "vertex index beyond cap")
	`DTF_NEVER(a_cnt_cap, deg_q > CNT_CAP, "removed count beyond cap")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the degenerate triangle filter unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dtf_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	localparam int COORD_MIN     = -8388608;
	localparam int COORD_MAX     = 8388607;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES  = 120;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	dtf_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	dtf_out_t out_data;

	// Predicted counters of the filter
	int unsigned vertex_cursor = 0;
	int unsigned culled_total  = 0;
	dtf_out_t    pending_verdicts[$];

	int errors        = 0;
	int sender_idle   = 0;
	int receiver_idle = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	degenerate_triangle_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic point_t pt(int x, int y, int z);
		point_t p;
		p.x = x[COORD_W-1:0];
		p.y = y[COORD_W-1:0];
		p.z = z[COORD_W-1:0];
		return p;
	endfunction

	function automatic dtf_in_t make_item(bit first, point_t a, point_t b, point_t c);
		dtf_in_t r;
		r.first_of_mesh = first;
		r.a_x = a.x;
		r.a_y = a.y;
		r.a_z = a.z;
		r.b_x = b.x;
		r.b_y = b.y;
		r.b_z = b.z;
		r.c_x = c.x;
		r.c_y = c.y;
		r.c_z = c.z;
		return r;
	endfunction

	function automatic longint unsigned square_of_diff(coord_t p, coord_t q);
		longint d;
		d = longint'($signed(p)) - longint'($signed(q));
		if (d < 0)
			d = -d;
		return longint'(d * d);
	endfunction

	// Floor of the Euclidean distance, in the same Q12.12 units as the coordinates
	function automatic longint unsigned edge_length(point_t p, point_t q);
		longint unsigned sum;
		longint unsigned root;
		longint unsigned trial;
		sum = square_of_diff(p.x, q.x) + square_of_diff(p.y, q.y) + square_of_diff(p.z, q.z);
		root = 0;
		for (int b = 25; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= sum)
				root = trial;
		end
		return root;
	endfunction

	function automatic dtf_out_t cull_triangle(dtf_in_t item);
		dtf_out_t r;
		point_t a;
		point_t b;
		point_t c;
		longint unsigned len_ac;
		longint unsigned len_bc;
		longint unsigned len_ab;
		a = '{item.a_x, item.a_y, item.a_z};
		b = '{item.b_x, item.b_y, item.b_z};
		c = '{item.c_x, item.c_y, item.c_z};
		if (item.first_of_mesh) begin
			vertex_cursor = 0;
			culled_total = 0;
		end
		len_ac = edge_length(a, c);
		len_bc = edge_length(b, c);
		len_ab = edge_length(a, b);
		r.keep = (len_ac + len_bc > len_ab) && (len_ac + len_ab > len_bc)
			&& (len_bc + len_ab > len_ac);
		if (r.keep) begin
			r.new_first_index = vertex_cursor[IDX_W-1:0];
			if (vertex_cursor + 3 <= IDX_CAP)
				vertex_cursor += 3;
			else
				vertex_cursor = IDX_CAP;
		end else begin
			r.new_first_index = '0;
			if (culled_total < CNT_CAP)
				culled_total++;
		end
		r.removed_count = culled_total[CNT_W-1:0];
		return r;
	endfunction

	function automatic int gap_length();
		if ($urandom_range(9) == 0)
			return $urandom_range(20, 200);
		return $urandom_range(1, 3);
	endfunction

	// Spread of zero means anywhere in the coordinate range
	function automatic point_t rand_point(int spread);
		if (spread == 0)
			return pt($urandom, $urandom, $urandom);
		return pt(int'($urandom_range(0, 2 * spread)) - spread,
			int'($urandom_range(0, 2 * spread)) - spread,
			int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic point_t shift(point_t base, point_t step, int m);
		return pt(int'($signed(base.x)) + m * int'($signed(step.x)),
			int'($signed(base.y)) + m * int'($signed(step.y)),
			int'($signed(base.z)) + m * int'($signed(step.z)));
	endfunction

	function automatic dtf_in_t random_triangle();
		point_t a;
		point_t b;
		point_t c;
		int kind;
		kind = $urandom_range(99);
		a = rand_point(0);
		b = rand_point(0);
		c = rand_point(0);
		if (kind < 25) begin
			// keep the full-range vertices
		end else if (kind < 40) begin
			a = rand_point(64);
			b = rand_point(64);
			c = rand_point(64);
		end else if (kind < 55) begin
			// collinear: C lies on the line through A and B
			a = rand_point(1 << 20);
			b = rand_point(2000);
			c = shift(a, b, int'($urandom_range(0, 6)) - 3);
			b = shift(a, b, 1);
		end else if (kind < 65) begin
			case ($urandom_range(2))
				0: b = a;
				1: c = a;
				default: c = b;
			endcase
		end else if (kind < 80) begin
			a = rand_point(2);
			b = rand_point(2);
			c = rand_point(2);
		end else begin
			b = shift(a, rand_point(8), 1);
			c = shift(a, rand_point(8), 1);
		end
		return make_item($urandom_range(39) == 0, a, b, c);
	endfunction

	task automatic send_triangle(dtf_in_t item);
		int gap;
		if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			gap = gap_length();
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		pending_verdicts.push_back(cull_triangle(item));
		@(negedge clk);
	endtask

	task automatic test_basic_shapes();
		send_triangle(make_item(1, pt(0, 0, 0), pt(4096, 0, 0), pt(0, 4096, 0)));
		send_triangle(make_item(0, pt(4096, 0, 0), pt(0, 4096, 0), pt(0, 0, 4096)));
		send_triangle(make_item(0, pt(100, -100, 5), pt(100, -100, 5), pt(100, -100, 5)));
		send_triangle(make_item(0, pt(-7, 8, 9), pt(-7, 8, 9), pt(300, 0, -300)));
		send_triangle(make_item(0, pt(0, 0, 0), pt(1, 0, 0), pt(2, 0, 0)));
		send_triangle(make_item(0, pt(0, 0, 0), pt(3000, 3000, 3000),
			pt(-3000, -3000, -3000)));
	endtask

	task automatic test_extreme_coords();
		send_triangle(make_item(0, pt(COORD_MIN, COORD_MIN, COORD_MIN),
			pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MIN, COORD_MAX, COORD_MIN)));
		send_triangle(make_item(0, pt(COORD_MAX, COORD_MIN, COORD_MAX),
			pt(COORD_MIN, COORD_MAX, COORD_MIN), pt(COORD_MAX, COORD_MAX, COORD_MAX)));
		send_triangle(make_item(0, pt(COORD_MAX, COORD_MAX, COORD_MAX),
			pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MAX, COORD_MAX, COORD_MAX)));
		send_triangle(make_item(0, pt(COORD_MIN, COORD_MIN, COORD_MIN),
			pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MIN, COORD_MIN, COORD_MIN)));
		send_triangle(make_item(0, pt('h555555, 'haaaaaa, 'h555555),
			pt('haaaaaa, 'h555555, 'haaaaaa), pt(0, 0, -1)));
		// full-width collinear: the two short edges add up exactly to the long one
		send_triangle(make_item(0, pt(COORD_MIN, 0, 0), pt(COORD_MAX, 0, 0), pt(0, 0, 0)));
	endtask

	task automatic test_rounding_and_mesh_start();
		// true lengths form a triangle, the rounded ones do not
		send_triangle(make_item(0, pt(0, 0, 0), pt(2, 0, 0), pt(1, 1, 0)));
		send_triangle(make_item(0, pt(0, 0, 0), pt(2, 0, 0), pt(1, 2, 0)));
		send_triangle(make_item(0, pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0)));
		send_triangle(make_item(1, pt(5, 5, 5), pt(5, 5, 5), pt(9, 9, 9)));
		send_triangle(make_item(1, pt(0, 0, 0), pt(8192, 0, 0), pt(0, 0, 8192)));
		send_triangle(make_item(0, pt(1, 2, 3), pt(2, 4, 6), pt(3, 6, 9)));
		send_triangle(make_item(1, pt(-1, -1, -1), pt(-1, -1, -1), pt(-1, -1, -1)));
	endtask

	task automatic test_output_backpressure();
		sender_idle = 0;
		hold_left = 800;
		for (int i = 0; i < 6; i++)
			send_triangle(make_item(i == 0, rand_point(0), rand_point(0), rand_point(0)));
	endtask

	task automatic test_random_meshes(int count, int send_gaps, int recv_stalls);
		sender_idle = send_gaps;
		receiver_idle = recv_stalls;
		for (int i = 0; i < count; i++)
			send_triangle(random_triangle());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_shapes();
		test_extreme_coords();
		test_rounding_and_mesh_start();
		test_output_backpressure();
		test_random_meshes(600, 30, 30);
		test_random_meshes(500, 0, 0);
		test_random_meshes(820, 60, 50);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stall runs, plus a forced hold-off when requested
	initial begin : receiver
		int run_left;
		bit stalling;
		run_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				stalling = receiver_idle > 0 && $urandom_range(99) < receiver_idle;
				out_stall <= stalling;
				run_left = stalling ? gap_length() : $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin : check_results
		dtf_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, out_data);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (out_data.keep !== want.keep) begin
					$display("%0t: keep expected %0b, got %0b", $time, want.keep,
						out_data.keep);
					errors++;
				end
				if (out_data.new_first_index !== want.new_first_index) begin
					$display("%0t: new_first_index expected %0d, got %0d", $time,
						want.new_first_index, out_data.new_first_index);
					errors++;
				end
				if (out_data.removed_count !== want.removed_count) begin
					$display("%0t: removed_count expected %0d, got %0d", $time,
						want.removed_count, out_data.removed_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run when no request moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time,
				pending_verdicts.size());
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule

>>> degenerate_triangle_filter_unit.f
+incdir+src
src/dtf_pkg.sv
src/dtf_ctrl.sv
src/dtf_dp.sv
src/degenerate_triangle_filter_unit.sv
verif/testbench.sv
